[hw/rtl/mcf_pkg.sv]
// mcf_pkg: shared types and constants of the message chunk framer
// holds the item structs, register indexes and header layout
// no dependencies
package mcf_pkg;

	// header layout
	localparam int HEADER_BYTES   = 21;
	localparam int HDR_ID_BYTES   = 8;
	localparam int HDR_INDEX_LO   = 8;
	localparam int HDR_INDEX_HI   = 9;
	localparam int HDR_TOTAL_LO   = 10;
	localparam int HDR_TOTAL_HI   = 11;
	localparam int HDR_FLAG       = 12;
	localparam int HDR_IDX_W      = $clog2(HEADER_BYTES);

	// default packet bound
	localparam int MAX_PACKET_BYTES_DEF = 2048;

	// register indexes and reset values
	localparam logic REG_PACKET_SIZE = 1'b0;
	localparam logic REG_CHUNK_LIMIT = 1'b1;
	localparam logic [15:0] PACKET_SIZE_RST = 16'd2048;
	localparam logic [15:0] CHUNK_LIMIT_RST = 16'd1024;

	// ceil division: 33-bit dividend, one quotient bit a step
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_of_message;
		logic [31:0] message_length;
		logic [63:0] message_id;
		logic        compressed_flag;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_packet;
		logic       message_error;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic div_start;
		logic div_step;
		logic commit_ok;
		logic commit_bad;
		logic load_err;
		logic load_hdr;
		logic load_data;
	} mcf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic first;
		logic basic_bad;
		logic drop;
		logic need_hdr;
		logic div_last;
		logic quot_bad;
		logic hdr_last;
	} mcf_sts_t;

endpackage

[hw/rtl/mcf_dp.sv]
// mcf_dp: datapath of the message chunk framer
// config registers, message state, serial divider, header mux, output register
// depends on mcf_pkg
module mcf_dp #(
	parameter int MAX_PACKET_BYTES = mcf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [15:0]       cfg_wdata,
	input  mcf_pkg::in_item_t in_item,
	input  mcf_pkg::mcf_cmd_t cmd,
	output mcf_pkg::mcf_sts_t sts,
	output mcf_pkg::out_item_t out_data
);
	import mcf_pkg::*;

	logic [15:0] packet_size_q;
	logic [15:0] chunk_limit_q;

	logic [7:0]  data_q;
	logic [31:0] len_q;
	logic [63:0] id_q;
	logic        flag_q;

	logic [31:0] bytes_left_q;
	logic [15:0] byte_in_packet_q;
	logic [15:0] packet_index_q;
	logic [15:0] packet_total_q;
	logic [63:0] held_id_q;
	logic        held_flag_q;
	logic        rejecting_q;
	logic [15:0] held_payload_q;

	logic [32:0]          num_q;
	logic [15:0]          rem_q;
	logic [15:0]          div_cap_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [HDR_IDX_W-1:0] hdr_idx_q;

	out_item_t out_q;

	logic [15:0] cap;
	logic [16:0] trial;
	logic        trial_ge;
	logic [15:0] bip_next;
	logic [31:0] left_next;
	logic        eop;
	logic [7:0]  hdr_byte;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_size_q <= PACKET_SIZE_RST;
			chunk_limit_q <= CHUNK_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PACKET_SIZE: packet_size_q <= cfg_wdata;
				REG_CHUNK_LIMIT: chunk_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// status toward the controller
	assign cap = packet_size_q - 16'(HEADER_BYTES);
	always_comb begin
		sts.first     = in_item.first_of_message;
		sts.basic_bad = (in_item.message_length == 32'd0)
			|| (packet_size_q <= 16'(HEADER_BYTES))
			|| (packet_size_q > 16'(MAX_PACKET_BYTES));
		sts.drop      = rejecting_q || (bytes_left_q == 32'd0);
		sts.need_hdr  = (byte_in_packet_q == 16'd0);
		sts.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		sts.quot_bad  = (num_q > {17'd0, chunk_limit_q});
		sts.hdr_last  = (hdr_idx_q == HDR_IDX_W'(HEADER_BYTES - 1));
	end

	// input item latch
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			data_q <= in_item.data_byte;
			len_q  <= in_item.message_length;
			id_q   <= in_item.message_id;
			flag_q <= in_item.compressed_flag;
		end
	end

	// restoring divider: ceil(len / cap) as floor((len + cap - 1) / cap)
	assign trial    = {rem_q, num_q[32]};
	assign trial_ge = (trial >= {1'b0, div_cap_q});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q     <= {1'b0, in_item.message_length} + {17'd0, cap} - 33'd1;
			rem_q     <= '0;
			div_cap_q <= cap;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? 16'(trial - {1'b0, div_cap_q}) : trial[15:0];
			num_q <= {num_q[31:0], trial_ge};
		end
	end

	// payload byte bookkeeping
	assign bip_next  = byte_in_packet_q + 16'd1;
	assign left_next = bytes_left_q - 32'd1;
	assign eop       = (bip_next >= held_payload_q) || (left_next == 32'd0);

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q     <= '0;
			byte_in_packet_q <= '0;
			packet_index_q   <= '0;
			packet_total_q   <= '0;
			held_id_q        <= '0;
			held_flag_q      <= 1'b0;
			rejecting_q      <= 1'b0;
			held_payload_q   <= '0;
		end else if (cmd.commit_bad) begin
			bytes_left_q     <= '0;
			byte_in_packet_q <= '0;
			packet_index_q   <= '0;
			packet_total_q   <= '0;
			rejecting_q      <= 1'b1;
		end else if (cmd.commit_ok) begin
			bytes_left_q     <= len_q;
			byte_in_packet_q <= '0;
			packet_index_q   <= '0;
			packet_total_q   <= num_q[15:0];
			held_id_q        <= id_q;
			held_flag_q      <= flag_q;
			rejecting_q      <= 1'b0;
			held_payload_q   <= div_cap_q;
		end else if (cmd.load_data) begin
			bytes_left_q <= left_next;
			if (eop) begin
				byte_in_packet_q <= '0;
				packet_index_q   <= packet_index_q + 16'd1;
			end else begin
				byte_in_packet_q <= bip_next;
			end
		end
	end

	// header byte select
	always_comb begin
		hdr_byte = 8'd0;
		priority if (hdr_idx_q < HDR_IDX_W'(HDR_ID_BYTES)) begin
			hdr_byte = held_id_q[{hdr_idx_q[2:0], 3'b000} +: 8];
		end else if (hdr_idx_q == HDR_IDX_W'(HDR_INDEX_LO)) begin
			hdr_byte = packet_index_q[7:0];
		end else if (hdr_idx_q == HDR_IDX_W'(HDR_INDEX_HI)) begin
			hdr_byte = packet_index_q[15:8];
		end else if (hdr_idx_q == HDR_IDX_W'(HDR_TOTAL_LO)) begin
			hdr_byte = packet_total_q[7:0];
		end else if (hdr_idx_q == HDR_IDX_W'(HDR_TOTAL_HI)) begin
			hdr_byte = packet_total_q[15:8];
		end else if (hdr_idx_q == HDR_IDX_W'(HDR_FLAG)) begin
			hdr_byte = {7'd0, held_flag_q};
		end else begin
			hdr_byte = 8'd0;
		end
	end

	// header byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= '0;
		end else if (cmd.load_hdr) begin
			hdr_idx_q <= sts.hdr_last ? '0 : hdr_idx_q + HDR_IDX_W'(1);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			out_q <= '{out_byte: 8'd0, end_of_packet: 1'b0, message_error: 1'b1};
		end else if (cmd.load_hdr) begin
			out_q <= '{out_byte: hdr_byte, end_of_packet: 1'b0, message_error: 1'b0};
		end else if (cmd.load_data) begin
			out_q <= '{out_byte: data_q, end_of_packet: eop, message_error: 1'b0};
		end
	end
	assign out_data = out_q;

endmodule

[hw/rtl/mcf_ctrl.sv]
// mcf_ctrl: controller of the message chunk framer
// sequences accept, divide, check, header burst and payload byte; owns out valid
// depends on mcf_pkg
module mcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mcf_pkg::mcf_sts_t sts,
	output mcf_pkg::mcf_cmd_t cmd
);
	import mcf_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_ERR   = 3'd3;
	localparam logic [2:0] S_HDR   = 3'd4;
	localparam logic [2:0] S_DATA  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       load_ok;
	logic       in_fire;
	logic       any_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign load_ok  = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		cmd.latch_in = in_fire;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					priority if (sts.first && sts.basic_bad) begin
						cmd.commit_bad = 1'b1;
						state_next     = S_ERR;
					end else if (sts.first) begin
						cmd.div_start = 1'b1;
						state_next    = S_DIV;
					end else if (sts.drop) begin
						state_next = S_IDLE;
					end else if (sts.need_hdr) begin
						state_next = S_HDR;
					end else begin
						state_next = S_DATA;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.quot_bad) begin
					cmd.commit_bad = 1'b1;
					state_next     = S_ERR;
				end else begin
					cmd.commit_ok = 1'b1;
					state_next    = S_HDR;
				end
			end
			S_ERR: begin
				if (load_ok) begin
					cmd.load_err = 1'b1;
					state_next   = S_IDLE;
				end
			end
			S_HDR: begin
				if (load_ok) begin
					cmd.load_hdr = 1'b1;
					if (sts.hdr_last) begin
						state_next = S_DATA;
					end
				end
			end
			S_DATA: begin
				if (load_ok) begin
					cmd.load_data = 1'b1;
					state_next    = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// output valid flag
	assign any_load = cmd.load_err || cmd.load_hdr || cmd.load_data;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (any_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

endmodule

[hw/rtl/message_chunk_framer.sv]
// message_chunk_framer: top level, splits a byte stream into headed packets
// instantiates mcf_ctrl and mcf_dp; depends on mcf_pkg
//
// channel   direction  handshake             payload
// in        to block   in_valid / in_ready   in_item (in_item_t)
// out       from block out_valid / out_ready out_data (out_item_t)
// cfg       to block   cfg_we                cfg_idx, cfg_wdata
//
// a payload byte inside a packet is accepted, then loaded into the output register
// the first payload byte of a packet is preceded by the 21 header bytes
// a first byte of a message first runs the 33 steps of the serial divider
// for the packet count, then the chunk limit check
// reset clears control state and sets the config registers to their defaults
// out_ready low holds the controller at its next output load; the input
// channel is taken again while the last result still waits in the output register
module message_chunk_framer #(
	parameter int MAX_PACKET_BYTES = mcf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mcf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mcf_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_wdata
);
	import mcf_pkg::*;

	mcf_cmd_t cmd;
	mcf_sts_t sts;

	// controller
	mcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	mcf_dp #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

	// one item at a time: an item that is not dropped closes the input
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (sts.first || !sts.drop)) |=> !in_ready)
		else $error("input accepted twice in a row");

	// no output load while waiting for input
	a_idle_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.load_err || cmd.load_hdr || cmd.load_data))
		else $error("output loaded while idle");

	// a message passes only within the chunk limit
	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_ok |-> !sts.quot_bad)
		else $error("message committed above chunk limit");

	// an error item carries no byte and no packet end
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.message_error) |->
			(out_data.out_byte == 8'd0 && !out_data.end_of_packet))
		else $error("error item with payload");

endmodule
